>>> rtl/ecal_pkg.sv
// Shared types and constants for the epoch to calendar converter.
package ecal_pkg;

   // front to back queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int SEC_W  = 33;
   localparam int FRAC_W = 16;
   localparam int DAY_W  = 17;
   localparam int SOD_W  = 17;

   // seconds are biased by a whole number of days so the floor split works unsigned
   localparam longint unsigned DAY_SECONDS  = 86400;
   localparam longint unsigned BIAS_DAYS    = 49711;
   localparam longint unsigned BIAS_SECONDS = DAY_SECONDS * BIAS_DAYS;

   // 86400 = 2^7 * 675
   localparam int              DAY_LOW_W       = 7;
   localparam longint unsigned DAY_ODD         = 675;
   localparam int              DAY_RECIP_SHIFT = 37;
   localparam longint unsigned DAY_RECIP       =
      ((64'd1 << DAY_RECIP_SHIFT) + DAY_ODD - 1) / DAY_ODD;

   // biased day index of 1900-01-01 and number of days in 1900..2099
   localparam longint unsigned DAYS_1900  = 24144;
   localparam longint unsigned DAYS_SPAN  = 73049;
   localparam longint unsigned YEAR_DAYS  = 365;
   localparam longint unsigned QUAD_DAYS  = 1461;
   localparam int              QUAD_SHIFT = 28;
   localparam longint unsigned QUAD_RECIP =
      ((64'd1 << QUAD_SHIFT) + QUAD_DAYS - 1) / QUAD_DAYS;

   localparam logic [11:0] BASE_YEAR       = 12'd1900;
   localparam logic [11:0] FIRST_QUAD_YEAR = 12'd1901;

   localparam longint unsigned HOUR_SECONDS = 3600;
   localparam int              HOUR_SHIFT   = 29;
   localparam longint unsigned HOUR_RECIP   =
      ((64'd1 << HOUR_SHIFT) + HOUR_SECONDS - 1) / HOUR_SECONDS;

   localparam longint unsigned MIN_SECONDS = 60;
   localparam int              MIN_SHIFT   = 18;
   localparam longint unsigned MIN_RECIP   =
      ((64'd1 << MIN_SHIFT) + MIN_SECONDS - 1) / MIN_SECONDS;

   // days before each month in a common year
   localparam logic [8:0] MONTH_START [0:11] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   typedef struct packed {
      logic [DAY_W-1:0]  day_index;
      logic [SOD_W-1:0]  sod;
      logic [FRAC_W-1:0] frac;
   } ecal_entry_type;

   typedef struct packed {
      logic           valid;
      ecal_entry_type entry;
   } ecal_push_type;

endpackage

>>> rtl/epoch_to_calendar.sv
// Top level of the epoch seconds to Gregorian calendar converter.
//
// Usage:
//   Request channel: drive req_epoch_seconds (signed, floored whole seconds since
//   1970-01-01) and req_epoch_fraction with start high; the transaction is taken
//   at the rising edge where start is high and busy is low.
//   Response channel: each transaction gives one result, shown for a single cycle
//   with rsp_strobe high. The receiver cannot stall, so every result is taken.
//   Years outside 1900..2099 return rsp_range_error high and all other fields zero.
// Timing:
//   Two front stages (bias add, reciprocal multiply by 1/675), the queue, and five
//   back stages (range check, four-year cycle and hour multiplies, month lookup)
//   lie between the accepting edge and the cycle with rsp_strobe high.
//   Throughput is one transaction per cycle; the back end drains the 4-entry queue
//   every cycle, so busy stays low while requests stream.
// Reset:
//   Synchronous, active high. It empties the queue and the pipeline valid bits;
//   nothing else is reset.
module epoch_to_calendar
   import ecal_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [SEC_W-1:0] req_epoch_seconds,
   input  logic [FRAC_W-1:0]       req_epoch_fraction,
   output logic                    rsp_strobe,
   output logic [11:0]             rsp_year,
   output logic [3:0]              rsp_month,
   output logic [4:0]              rsp_day_of_month,
   output logic [8:0]              rsp_day_of_year,
   output logic [4:0]              rsp_hour,
   output logic [5:0]              rsp_minute,
   output logic [5:0]              rsp_second,
   output logic [FRAC_W-1:0]       rsp_second_fraction,
   output logic                    rsp_range_error
);

   logic                  accept;
   ecal_push_type         push;
   logic [1:0]            inflight;
   ecal_entry_type        head;
   logic                  empty;
   logic [FIFO_CNT_W-1:0] fifo_count;

   // reserve a queue slot for every transaction still in the front stages
   assign busy   = (4'(fifo_count) + 4'(inflight)) >= 4'(FIFO_DEPTH);
   assign accept = start && !busy;

   ecal_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .secs     (req_epoch_seconds),
      .frac     (req_epoch_fraction),
      .push     (push),
      .inflight (inflight)
   );

   ecal_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (!empty),
      .head  (head),
      .empty (empty),
      .count (fifo_count)
   );

   ecal_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (!empty),
      .entry            (head),
      .out_strobe       (rsp_strobe),
      .out_year         (rsp_year),
      .out_month        (rsp_month),
      .out_day_of_month (rsp_day_of_month),
      .out_day_of_year  (rsp_day_of_year),
      .out_hour         (rsp_hour),
      .out_minute       (rsp_minute),
      .out_second       (rsp_second),
      .out_fraction     (rsp_second_fraction),
      .out_range_error  (rsp_range_error)
   );

endmodule

>>> rtl/ecal_front.sv
// Front end: accepts timestamps and splits them into day index and second of day.
module ecal_front
   import ecal_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic signed [SEC_W-1:0]  secs,
   input  logic [FRAC_W-1:0]        frac,
   output ecal_push_type            push,
   output logic [1:0]               inflight
);

   localparam int U_W  = SEC_W + 1;
   localparam int HI_W = U_W - DAY_LOW_W;
   localparam int P_W  = HI_W + 28;

   logic            s1_valid_ff, s2_valid_ff;
   logic [HI_W-1:0] s1_hi_ff, s2_hi_ff;
   logic [DAY_LOW_W-1:0] s1_lo_ff, s2_lo_ff;
   logic [FRAC_W-1:0]    s1_frac_ff, s2_frac_ff;
   logic [DAY_W-1:0]     s2_q_ff;

   logic [U_W-1:0]  biased;
   logic [P_W-1:0]  prod;
   logic [DAY_W-1:0] q_in;
   logic [HI_W-1:0] rem_full;

   assign biased   = {secs[SEC_W-1], secs} + U_W'(BIAS_SECONDS);
   assign prod     = P_W'(s1_hi_ff) * P_W'(DAY_RECIP);
   assign q_in     = prod[DAY_RECIP_SHIFT +: DAY_W];
   assign rem_full = s2_hi_ff - HI_W'(s2_q_ff) * HI_W'(DAY_ODD);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_hi_ff   <= biased[U_W-1:DAY_LOW_W];
      s1_lo_ff   <= biased[DAY_LOW_W-1:0];
      s1_frac_ff <= frac;
      s2_hi_ff   <= s1_hi_ff;
      s2_lo_ff   <= s1_lo_ff;
      s2_frac_ff <= s1_frac_ff;
      s2_q_ff    <= q_in;
   end

   always_comb begin
      push.valid           = s2_valid_ff;
      push.entry.day_index = s2_q_ff;
      push.entry.sod       = {rem_full[SOD_W-DAY_LOW_W-1:0], s2_lo_ff};
      push.entry.frac      = s2_frac_ff;
   end

   assign inflight = 2'(s1_valid_ff) + 2'(s2_valid_ff);

endmodule

>>> rtl/ecal_fifo.sv
// Small queue between the front end and the calendar back end.
module ecal_fifo
   import ecal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ecal_push_type         push,
   input  logic                  pop,
   output ecal_entry_type        head,
   output logic                  empty,
   output logic [FIFO_CNT_W-1:0] count
);

   ecal_entry_type        slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = push.valid && (count_ff != FIFO_CNT_W'(FIFO_DEPTH));

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

>>> rtl/ecal_back.sv
// Back end: resolves day index into year, month and day, and second of day into h:m:s.
module ecal_back
   import ecal_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ecal_entry_type    entry,
   output logic              out_strobe,
   output logic [11:0]       out_year,
   output logic [3:0]        out_month,
   output logic [4:0]        out_day_of_month,
   output logic [8:0]        out_day_of_year,
   output logic [4:0]        out_hour,
   output logic [5:0]        out_minute,
   output logic [5:0]        out_second,
   output logic [FRAC_W-1:0] out_fraction,
   output logic              out_range_error
);

   localparam int HP_W = SOD_W + 18;
   localparam int QP_W = DAY_W + 18;
   localparam int MP_W = 12 + 13;

   // stage 1
   logic              b1_valid_ff, b1_err_ff, b1_early_ff;
   logic [DAY_W-1:0]  b1_e_ff;
   logic [8:0]        b1_d_ff;
   logic [SOD_W-1:0]  b1_sod_ff;
   logic [4:0]        b1_hour_ff;
   logic [FRAC_W-1:0] b1_frac_ff;
   // stage 2
   logic              b2_valid_ff, b2_err_ff, b2_early_ff;
   logic [DAY_W-1:0]  b2_e_ff;
   logic [8:0]        b2_d_ff;
   logic [5:0]        b2_quad_ff;
   logic [11:0]       b2_hrem_ff;
   logic [4:0]        b2_hour_ff;
   logic [FRAC_W-1:0] b2_frac_ff;
   // stage 3
   logic              b3_valid_ff, b3_err_ff, b3_early_ff;
   logic [10:0]       b3_r_ff;
   logic [8:0]        b3_d_ff;
   logic [5:0]        b3_quad_ff;
   logic [11:0]       b3_hrem_ff;
   logic [5:0]        b3_minute_ff;
   logic [4:0]        b3_hour_ff;
   logic [FRAC_W-1:0] b3_frac_ff;
   // stage 4
   logic              b4_valid_ff, b4_err_ff, b4_leap_ff;
   logic [11:0]       b4_year_ff;
   logic [8:0]        b4_doy_ff;
   logic [5:0]        b4_second_ff, b4_minute_ff;
   logic [4:0]        b4_hour_ff;
   logic [FRAC_W-1:0] b4_frac_ff;
   // result register
   logic              out_strobe_ff, out_err_ff;
   logic [11:0]       out_year_ff;
   logic [3:0]        out_month_ff;
   logic [4:0]        out_dom_ff;
   logic [8:0]        out_doy_ff;
   logic [4:0]        out_hour_ff;
   logic [5:0]        out_minute_ff, out_second_ff;
   logic [FRAC_W-1:0] out_frac_ff;

   logic [DAY_W-1:0]  d_in, e_in;
   logic              err_in, early_in;
   logic [HP_W-1:0]   hour_prod;
   logic [QP_W-1:0]   quad_prod;
   logic [SOD_W-1:0]  hrem_full;
   logic [DAY_W-1:0]  r_full;
   logic [MP_W-1:0]   min_prod;
   logic [1:0]        yoff;
   logic [10:0]       yoff_days, doy0;
   logic [11:0]       year_in, sec_full;
   logic [8:0]        doy_in;
   logic              leap_in;
   logic [3:0]        mon_idx;
   logic [8:0]        mon_start, dom_full;

   // stage 1: range check, offset from 1901, hour estimate
   always_comb begin
      err_in    = (entry.day_index < DAY_W'(DAYS_1900)) ||
                  (entry.day_index >= DAY_W'(DAYS_1900 + DAYS_SPAN));
      d_in      = entry.day_index - DAY_W'(DAYS_1900);
      early_in  = d_in < DAY_W'(YEAR_DAYS);
      e_in      = d_in - DAY_W'(YEAR_DAYS);
      hour_prod = HP_W'(entry.sod) * HP_W'(HOUR_RECIP);
   end

   // stage 2: four-year cycle estimate, minutes-and-seconds remainder
   always_comb begin
      quad_prod = QP_W'(b1_e_ff) * QP_W'(QUAD_RECIP);
      hrem_full = b1_sod_ff - SOD_W'(b1_hour_ff) * SOD_W'(HOUR_SECONDS);
   end

   // stage 3: day within the cycle, minute estimate
   always_comb begin
      r_full   = b2_e_ff - DAY_W'(b2_quad_ff) * DAY_W'(QUAD_DAYS);
      min_prod = MP_W'(b2_hrem_ff) * MP_W'(MIN_RECIP);
   end

   // stage 4: year in cycle; the last day of a cycle belongs to the leap year
   always_comb begin
      if (b3_r_ff >= 11'(3 * YEAR_DAYS)) begin
         yoff = 2'd3;
      end else if (b3_r_ff >= 11'(2 * YEAR_DAYS)) begin
         yoff = 2'd2;
      end else if (b3_r_ff >= 11'(YEAR_DAYS)) begin
         yoff = 2'd1;
      end else begin
         yoff = 2'd0;
      end
      yoff_days = 11'(yoff) * 11'(YEAR_DAYS);
      doy0      = b3_r_ff - yoff_days;
      sec_full  = b3_hrem_ff - 12'(b3_minute_ff) * 12'(MIN_SECONDS);
      if (b3_early_ff) begin
         year_in = BASE_YEAR;
         doy_in  = b3_d_ff + 9'd1;
         leap_in = 1'b0;
      end else begin
         year_in = FIRST_QUAD_YEAR + {4'd0, b3_quad_ff, 2'b00} + 12'(yoff);
         doy_in  = doy0[8:0] + 9'd1;
         leap_in = (yoff == 2'd3);
      end
   end

   // stage 5: month lookup
   always_comb begin
      mon_idx = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (b4_doy_ff > MONTH_START[k] + 9'((b4_leap_ff && k >= 2) ? 1 : 0)) begin
            mon_idx = 4'(k);
         end
      end
      mon_start = MONTH_START[mon_idx] + 9'((b4_leap_ff && mon_idx >= 4'd2) ? 1 : 0);
      dom_full  = b4_doy_ff - mon_start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff   <= 1'b0;
         b2_valid_ff   <= 1'b0;
         b3_valid_ff   <= 1'b0;
         b4_valid_ff   <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         b1_valid_ff   <= in_valid;
         b2_valid_ff   <= b1_valid_ff;
         b3_valid_ff   <= b2_valid_ff;
         b4_valid_ff   <= b3_valid_ff;
         out_strobe_ff <= b4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_err_ff    <= err_in;
      b1_early_ff  <= early_in;
      b1_e_ff      <= e_in;
      b1_d_ff      <= d_in[8:0];
      b1_sod_ff    <= entry.sod;
      b1_hour_ff   <= hour_prod[HOUR_SHIFT +: 5];
      b1_frac_ff   <= entry.frac;

      b2_err_ff    <= b1_err_ff;
      b2_early_ff  <= b1_early_ff;
      b2_e_ff      <= b1_e_ff;
      b2_d_ff      <= b1_d_ff;
      b2_quad_ff   <= quad_prod[QUAD_SHIFT +: 6];
      b2_hrem_ff   <= hrem_full[11:0];
      b2_hour_ff   <= b1_hour_ff;
      b2_frac_ff   <= b1_frac_ff;

      b3_err_ff    <= b2_err_ff;
      b3_early_ff  <= b2_early_ff;
      b3_r_ff      <= r_full[10:0];
      b3_d_ff      <= b2_d_ff;
      b3_quad_ff   <= b2_quad_ff;
      b3_hrem_ff   <= b2_hrem_ff;
      b3_minute_ff <= min_prod[MIN_SHIFT +: 6];
      b3_hour_ff   <= b2_hour_ff;
      b3_frac_ff   <= b2_frac_ff;

      b4_err_ff    <= b3_err_ff;
      b4_leap_ff   <= leap_in;
      b4_year_ff   <= year_in;
      b4_doy_ff    <= doy_in;
      b4_second_ff <= sec_full[5:0];
      b4_minute_ff <= b3_minute_ff;
      b4_hour_ff   <= b3_hour_ff;
      b4_frac_ff   <= b3_frac_ff;

      // out-of-range timestamps report zeroed fields
      out_err_ff    <= b4_err_ff;
      out_year_ff   <= b4_err_ff ? '0 : b4_year_ff;
      out_month_ff  <= b4_err_ff ? '0 : mon_idx + 4'd1;
      out_dom_ff    <= b4_err_ff ? '0 : dom_full[4:0];
      out_doy_ff    <= b4_err_ff ? '0 : b4_doy_ff;
      out_hour_ff   <= b4_err_ff ? '0 : b4_hour_ff;
      out_minute_ff <= b4_err_ff ? '0 : b4_minute_ff;
      out_second_ff <= b4_err_ff ? '0 : b4_second_ff;
      out_frac_ff   <= b4_err_ff ? '0 : b4_frac_ff;
   end

   assign out_strobe       = out_strobe_ff;
   assign out_year         = out_year_ff;
   assign out_month        = out_month_ff;
   assign out_day_of_month = out_dom_ff;
   assign out_day_of_year  = out_doy_ff;
   assign out_hour         = out_hour_ff;
   assign out_minute       = out_minute_ff;
   assign out_second       = out_second_ff;
   assign out_fraction     = out_frac_ff;
   assign out_range_error  = out_err_ff;

endmodule
